@@ hw/rtl/utt_pkg.sv @@
// shared types and constants for the utf-8 to utf-16 transcoder
package utt_pkg;

  localparam int unsigned UttMaxUnits = 3;

  // lead byte boundaries
  localparam logic [7:0] LeadCont  = 8'h80;
  localparam logic [7:0] LeadTwo   = 8'hC0;
  localparam logic [7:0] LeadThree = 8'hE0;
  localparam logic [7:0] LeadFour  = 8'hF0;
  localparam logic [7:0] LeadBad   = 8'hF8;

  // trailer counts of an open sequence
  localparam logic [1:0] SeqNone  = 2'd0;
  localparam logic [1:0] SeqTwo   = 2'd1;
  localparam logic [1:0] SeqThree = 2'd2;
  localparam logic [1:0] SeqFour  = 2'd3;

  localparam logic [19:0] SuppOffset = 20'h10000;
  localparam logic [4:0]  SurrTop    = 5'b11011;
  localparam logic [5:0]  SurrHigh   = 6'b110110;
  localparam logic [5:0]  SurrLow    = 6'b110111;

  typedef struct packed {
    logic [1:0]  trl;
    logic [1:0]  seq;
    logic [20:0] acc;
  } utt_state_t;

  typedef struct packed {
    logic [1:0]       cnt;
    logic [2:0][15:0] unit;
    logic [2:0]       term;
  } utt_bundle_t;

endpackage

@@ hw/rtl/utf8_to_utf16_transcoder.sv @@
// top level of the streaming utf-8 to utf-16 transcoder
//
// input channel: in_valid / in_stall carry one utf-8 byte per beat, with
// in_last_byte set on the byte that ends a string
// output channel: out_valid / out_stall carry one utf-16 code unit per beat;
// out_run_last marks the last unit caused by an input byte and
// out_string_end marks the zero terminator appended after every string
// a byte is decoded as it is accepted and its units (zero to three) land in
// a result register, so the first unit appears in the cycle after acceptance
// throughput: one byte per cycle while each byte yields at most one unit
// and the receiver does not stall; a byte yielding more holds the input
// until the single output beat per cycle drains it to its last unit
// the input is taken while the result register holds at most one unit that
// leaves in the same cycle, so a lone waiting unit does not block a byte
// when the receiver stalls, the current unit holds and the input stalls
// once the result register cannot be freed
// reset clears the decode state (no sequence open) and empties the result
// register
module utf8_to_utf16_transcoder
  import utt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_utf8_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_utf16_unit,
  output logic        out_run_last,
  output logic        out_string_end
);

  utt_state_t       st_r, st_nxt;
  utt_bundle_t      dec_bnd;
  logic [1:0]       rem_r, rem_nxt;
  logic [2:0][15:0] unit_r, unit_nxt;
  logic [2:0]       term_r, term_nxt;
  logic             load;
  logic             pop;

  utt_decode u_dec (
    .utf8_byte (in_utf8_byte),
    .last_byte (in_last_byte),
    .st        (st_r),
    .st_nxt    (st_nxt),
    .bnd       (dec_bnd)
  );

  // result register frees when empty or when its final unit leaves now
  assign in_stall = !((rem_r == 2'd0) || ((rem_r == 2'd1) && !out_stall));
  assign load     = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  assign out_valid      = (rem_r != 2'd0);
  assign out_utf16_unit = unit_r[0];
  assign out_run_last   = (rem_r == 2'd1);
  assign out_string_end = term_r[0];

  always_comb begin
    rem_nxt  = rem_r;
    unit_nxt = unit_r;
    term_nxt = term_r;
    if (load) begin
      rem_nxt  = dec_bnd.cnt;
      unit_nxt = dec_bnd.unit;
      term_nxt = dec_bnd.term;
    end else if (pop) begin
      // shift the next unit to the head
      rem_nxt  = rem_r - 2'd1;
      unit_nxt = {16'd0, unit_r[2], unit_r[1]};
      term_nxt = {1'b0, term_r[2], term_r[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '0;
      rem_r <= 2'd0;
    end else begin
      if (load) begin
        st_r <= st_nxt;
      end
      rem_r <= rem_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    unit_r <= unit_nxt;
    term_r <= term_nxt;
  end

endmodule

@@ hw/rtl/utt_decode.sv @@
// byte decoder: next decode state and the units one byte produces
module utt_decode
  import utt_pkg::*;
(
  input  logic        [7:0] utf8_byte,
  input  logic              last_byte,
  input  utt_state_t        st,
  output utt_state_t        st_nxt,
  output utt_bundle_t       bnd
);

  always_comb begin
    logic [20:0] acc_sh;
    logic [19:0] off;
    logic [15:0] u0;
    logic [15:0] u1;
    logic [1:0]  ndata;

    acc_sh = {st.acc[14:0], utf8_byte[5:0]};
    off    = acc_sh[19:0] - SuppOffset;
    u0     = '0;
    u1     = '0;
    ndata  = 2'd0;
    st_nxt = st;

    if (st.trl != 2'd0) begin
      if (st.trl == 2'd1) begin
        // sequence completes
        unique case (st.seq)
          SeqTwo: begin
            u0    = {5'd0, acc_sh[10:0]};
            ndata = 2'd1;
          end
          SeqThree: begin
            u0    = acc_sh[15:0];
            ndata = (acc_sh[15:11] == SurrTop) ? 2'd0 : 2'd1;
          end
          default: begin
            u0    = {SurrHigh, off[19:10]};
            u1    = {SurrLow, off[9:0]};
            ndata = 2'd2;
          end
        endcase
        st_nxt.trl = 2'd0;
        st_nxt.seq = SeqNone;
        st_nxt.acc = '0;
      end else begin
        st_nxt.trl = st.trl - 2'd1;
        st_nxt.acc = acc_sh;
      end
    end else if (utf8_byte < LeadCont) begin
      u0    = {8'd0, utf8_byte};
      ndata = 2'd1;
    end else if (utf8_byte < LeadTwo) begin
      // stray continuation, dropped
    end else if (utf8_byte < LeadThree) begin
      st_nxt.acc = {16'd0, utf8_byte[4:0]};
      st_nxt.trl = 2'd1;
      st_nxt.seq = SeqTwo;
    end else if (utf8_byte < LeadFour) begin
      st_nxt.acc = {17'd0, utf8_byte[3:0]};
      st_nxt.trl = 2'd2;
      st_nxt.seq = SeqThree;
    end else if (utf8_byte < LeadBad) begin
      st_nxt.acc = {18'd0, utf8_byte[2:0]};
      st_nxt.trl = 2'd3;
      st_nxt.seq = SeqFour;
    end else begin
      // invalid lead, dropped
    end

    bnd.unit[0] = u0;
    bnd.unit[1] = u1;
    bnd.unit[2] = '0;
    bnd.term    = '0;
    bnd.cnt     = ndata;
    if (last_byte) begin
      st_nxt.trl       = 2'd0;
      st_nxt.seq       = SeqNone;
      st_nxt.acc       = '0;
      bnd.unit[ndata]  = '0;
      bnd.term[ndata]  = 1'b1;
      bnd.cnt          = ndata + 2'd1;
    end
  end

endmodule

@@ bench/tb_utf8_to_utf16_transcoder.sv @@
// self-checking testbench for the utf-8 to utf-16 transcoder
module tb_utf8_to_utf16_transcoder
  import utt_pkg::*;
();

  // one expected utf-16 output beat
  typedef struct {
    logic [15:0] unit;
    logic        run_last;
    logic        string_end;
  } utf16_beat_t;

  // decodes accepted bytes the way the block should and holds the units still owed
  class transcode_tracker;
    logic [1:0]  trl_left = SeqNone;
    logic [1:0]  seq_len  = SeqNone;
    logic [20:0] code_acc = '0;
    utf16_beat_t step_units[$];
    utf16_beat_t owed_units[$];
    int errors     = 0;
    int units_seen = 0;
    int bytes_seen = 0;

    function void flag_mismatch(string what);
      $display("mismatch @%0t: %s", $time, what);
      errors++;
    endfunction

    function void add_unit(logic [15:0] unit, logic is_end);
      utf16_beat_t beat;
      beat.unit       = unit;
      beat.run_last   = 1'b0;
      beat.string_end = is_end;
      step_units.push_back(beat);
    endfunction

    function int owed();
      return owed_units.size();
    endfunction

    function void absorb_byte(logic [7:0] b, logic last);
      logic [20:0] cp;
      logic [19:0] off;
      bytes_seen++;
      step_units.delete();
      if (trl_left != SeqNone) begin
        // trailer: top bits ignored, six payload bits shifted in
        code_acc = {code_acc[14:0], b[5:0]};
        trl_left = trl_left - 2'd1;
        if (trl_left == SeqNone) begin
          cp = code_acc;
          case (seq_len)
            SeqTwo: begin
              add_unit({5'b0, cp[10:0]}, 1'b0);
            end
            SeqThree: begin
              // surrogate code points are dropped
              if (cp[15:11] != SurrTop) add_unit(cp[15:0], 1'b0);
            end
            default: begin
              off = cp[19:0] - SuppOffset;
              add_unit({SurrHigh, off[19:10]}, 1'b0);
              add_unit({SurrLow, off[9:0]}, 1'b0);
            end
          endcase
          seq_len  = SeqNone;
          code_acc = '0;
        end
      end else if (b < LeadCont) begin
        add_unit({8'h00, b}, 1'b0);
      end else if (b < LeadTwo) begin
        // stray continuation, nothing
      end else if (b < LeadThree) begin
        code_acc = {16'b0, b[4:0]};
        trl_left = SeqTwo;
        seq_len  = SeqTwo;
      end else if (b < LeadFour) begin
        code_acc = {17'b0, b[3:0]};
        trl_left = SeqThree;
        seq_len  = SeqThree;
      end else if (b < LeadBad) begin
        code_acc = {18'b0, b[2:0]};
        trl_left = SeqFour;
        seq_len  = SeqFour;
      end
      if (last) begin
        trl_left = SeqNone;
        seq_len  = SeqNone;
        code_acc = '0;
        add_unit(16'h0000, 1'b1);
      end
      if (step_units.size() > 0) step_units[step_units.size() - 1].run_last = 1'b1;
      foreach (step_units[i]) owed_units.push_back(step_units[i]);
    endfunction

    function void check_unit(logic [15:0] unit, logic run_last, logic string_end);
      utf16_beat_t want;
      if (owed_units.size() == 0) begin
        flag_mismatch($sformatf("unit %h arrived with nothing owed", unit));
        return;
      end
      want = owed_units.pop_front();
      units_seen++;
      if (unit !== want.unit)
        flag_mismatch($sformatf("unit %h, wanted %h", unit, want.unit));
      if (run_last !== want.run_last)
        flag_mismatch($sformatf("run_last %b, wanted %b (unit %h)", run_last, want.run_last,
                                want.unit));
      if (string_end !== want.string_end)
        flag_mismatch($sformatf("string_end %b, wanted %b (unit %h)", string_end,
                                want.string_end, want.unit));
    endfunction

    function void flush_check();
      if (owed_units.size() != 0)
        flag_mismatch($sformatf("%0d units never arrived", owed_units.size()));
    endfunction
  endclass

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 20;
  localparam int TotalBytes  = 210;

  // clock and synchronous active-low reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  // block inputs, all known from time zero
  logic       in_valid     = 1'b0;
  logic [7:0] in_utf8_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_stall    = 1'b0;

  // block outputs
  logic        in_stall;
  logic        out_valid;
  logic [15:0] out_utf16_unit;
  logic        out_run_last;
  logic        out_string_end;

  utf8_to_utf16_transcoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_utf8_byte   (in_utf8_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_utf16_unit (out_utf16_unit),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end)
  );

  transcode_tracker tracker = new();

  // calm stretches turn off idling on both sides
  bit calm = 1'b0;
  int cycle_count = 0;
  int stall_left = 0;
  int strings_sent = 0;
  logic [7:0] str_bytes[$];

  // directed beats as {last, byte}
  logic [8:0] directed_beats[$] = '{
    9'h000, 9'h07F,                  // ascii extremes
    9'h0C0, 9'h080,                  // smallest two-byte lead, overlong zero
    9'h0DF, 9'h0BF,                  // largest two-byte value
    9'h0ED, 9'h0A0, 9'h080,          // three-byte result in the surrogate range, dropped
    9'h0EF, 9'h0BF, 9'h0BF,          // largest three-byte value
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0FF,  // top four-byte lead, trailer with top bits set, wraps
    9'h080, 9'h0F8,                  // stray continuation and invalid lead
    9'h0C3, 9'h041,                  // trailer with wrong top bits still absorbed
    9'h0F0, 9'h090, 9'h080, 9'h180,  // surrogate pair then terminator on one byte
    9'h0E2, 9'h182                   // sequence cut off by end of string
  };

  function int draw_wait();
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  // watchdog: a hung handshake ends the run here
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  // receiver: check every accepted beat, then stall for a drawn number of cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        tracker.check_unit(out_utf16_unit, out_run_last, out_string_end);
        stall_left = draw_wait();
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  // sender: optional gap, then hold the beat until the block takes it
  task send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_utf8_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.absorb_byte(b, last);
  endtask

  // send the queued string, marking the final byte as its end
  task send_string();
    foreach (str_bytes[i]) send_byte(str_bytes[i], i == str_bytes.size() - 1);
    strings_sent++;
  endtask

  // stop sending until every owed unit has come out
  task hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.owed() != 0) @(posedge clk);
  endtask

  // queue a lead needing `need` trailers followed by `given` trailers
  function void add_seq(int need, int given, bit any_top);
    case (need)
      0:       str_bytes.push_back(8'($urandom_range(0, 127)));
      1:       str_bytes.push_back(LeadTwo | 8'($urandom_range(0, 31)));
      2:       str_bytes.push_back(LeadThree | 8'($urandom_range(0, 15)));
      default: str_bytes.push_back(LeadFour | 8'($urandom_range(0, 7)));
    endcase
    repeat (given) begin
      if (any_top) str_bytes.push_back(8'($urandom_range(0, 255)));
      else str_bytes.push_back(LeadCont | 8'($urandom_range(0, 63)));
    end
  endfunction

  initial begin
    int nchars;
    int pick;
    int need;
    bit drained_once;
    drained_once = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats
    foreach (directed_beats[i]) begin
      send_byte(directed_beats[i][7:0], directed_beats[i][8]);
      if (directed_beats[i][8]) strings_sent++;
    end

    // random strings, mostly well-formed with random content
    while (tracker.bytes_seen < TotalBytes) begin
      calm = ($urandom_range(0, 4) == 0);
      str_bytes.delete();
      nchars = $urandom_range(1, 6);
      repeat (nchars) begin
        pick = $urandom_range(0, 9);
        need = $urandom_range(0, 3);
        if (pick < 7) begin
          add_seq(need, need, 1'b0);
        end else if (pick == 7) begin
          // noise byte: stray, invalid or anything
          str_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (pick == 8) begin
          // trailers with arbitrary top bits
          add_seq(need, need, 1'b1);
        end else begin
          // short sequence, the next lead gets absorbed as a trailer
          need = $urandom_range(1, 3);
          add_seq(need, $urandom_range(0, need - 1), 1'b0);
        end
      end
      // sometimes end the string inside a sequence
      if ($urandom_range(0, 5) == 0) begin
        need = $urandom_range(1, 3);
        add_seq(need, $urandom_range(0, need - 1), 1'b0);
      end
      send_string();
      if (!drained_once && tracker.bytes_seen > TotalBytes / 2) begin
        hold_until_drained();
        drained_once = 1'b1;
      end
    end
    calm = 1'b0;

    // drain and give the block time to show anything extra
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.owed() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    tracker.flush_check();

    $display("sent %0d bytes in %0d strings, checked %0d utf-16 units",
             tracker.bytes_seen, strings_sent, tracker.units_seen);
    $display("covered every lead class, surrogate drop, pairs, truncation, stray and bad leads");
    if (tracker.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", tracker.errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
